/* src/binary_to_decimal_ascii_macros.svh */
// Assertion macros for the decimal text converter.
// Used by the converter and emitter modules; needs clk_i and rst_ni in scope.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`ifndef SYNTHESIS
`define BDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BDA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define BDA_ASSERT(lbl, prop, msg)
`define BDA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* src/bda_pkg.sv */
// Shared constants, types and BCD helpers for the decimal text converter.
// No dependencies.
package bda_pkg;

  localparam int unsigned InWidth    = 32;
  localparam int unsigned ValueWidth = 32;
  // Decimal digits needed for ValueWidth bits: floor(W * log10(2)) + 1.
  localparam int unsigned NumDigits  = (ValueWidth * 30103) / 100000 + 1;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CntWidth   = $clog2(ValueWidth);
  localparam int unsigned LeftWidth  = $clog2(NumDigits + 1);

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;

  typedef struct packed {
    logic                valid;
    logic                negative;
    logic [BcdWidth-1:0] bcd;
  } bda_conv_t;

  // Shift-add-3 correction: every digit of five or more gets three added.
  function automatic logic [BcdWidth-1:0] add3(input logic [BcdWidth-1:0] bcd);
    logic [BcdWidth-1:0] res;
    res = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  function automatic logic digits_ok(input logic [BcdWidth-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

/* src/bda_conv.sv */
// Bit-serial binary to BCD converter (shift-add-3), one input bit per cycle.
// Depends on bda_pkg and binary_to_decimal_ascii_macros.svh.
`include "binary_to_decimal_ascii_macros.svh"
module bda_conv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bda_pkg::InWidth-1:0]    value_bits_i,
  input  logic                           is_signed_i,
  output bda_pkg::bda_conv_t             conv_o,
  input  logic                           take_i
);

  typedef enum logic [2:0] {
    CvIdle = 3'b001,
    CvRun  = 3'b010,
    CvDone = 3'b100
  } cv_state_e;

  cv_state_e                         state_q, state_d;
  logic [bda_pkg::ValueWidth-1:0]    mag_q, mag_d;
  logic [bda_pkg::BcdWidth-1:0]      bcd_q, bcd_d;
  logic [bda_pkg::CntWidth-1:0]      cnt_q, cnt_d;
  logic                              neg_q, neg_d;

  logic [bda_pkg::InWidth+bda_pkg::ValueWidth-1:0] ext;
  logic [bda_pkg::ValueWidth-1:0]    word;
  logic                              word_neg;
  logic                              accept;
  logic [bda_pkg::BcdWidth-1:0]      bcd_adj;

  assign ext      = {{bda_pkg::ValueWidth{1'b0}}, value_bits_i};
  assign word     = ext[bda_pkg::ValueWidth-1:0];
  assign word_neg = is_signed_i & word[bda_pkg::ValueWidth-1];
  assign in_stall_o = (state_q != CvIdle);
  assign accept   = in_valid_i && !in_stall_o;
  assign bcd_adj  = bda_pkg::add3(bcd_q);

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    case (state_q)
      CvIdle: begin
        if (accept) begin
          mag_d   = word_neg ? (bda_pkg::ValueWidth'(0) - word) : word;
          neg_d   = word_neg;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = CvRun;
        end
      end
      CvRun: begin
        bcd_d = {bcd_adj[bda_pkg::BcdWidth-2:0], mag_q[bda_pkg::ValueWidth-1]};
        mag_d = {mag_q[bda_pkg::ValueWidth-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == bda_pkg::CntWidth'(bda_pkg::ValueWidth - 1)) begin
          state_d = CvDone;
        end
      end
      CvDone: begin
        if (take_i) begin
          state_d = CvIdle;
        end
      end
      default: state_d = CvIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CvIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign conv_o.valid    = (state_q == CvDone);
  assign conv_o.negative = neg_q;
  assign conv_o.bcd      = bcd_q;

  `BDA_ASSERT_NEXT(a_start_run, accept, (state_q == CvRun) && (cnt_q == '0), "conversion did not start")
  `BDA_ASSERT(a_bcd_legal, conv_o.valid |-> bda_pkg::digits_ok(bcd_q), "illegal BCD digit")

endmodule

/* src/bda_emit.sv */
// Character emitter: drops leading zeros, sends the sign if negative and then one digit
// per item through an output register. Depends on bda_pkg and the macro header.
`include "binary_to_decimal_ascii_macros.svh"
module bda_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bda_pkg::bda_conv_t conv_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         text_char_o,
  output logic               is_last_o
);

  typedef enum logic [3:0] {
    EmIdle   = 4'b0001,
    EmSkip   = 4'b0010,
    EmSign   = 4'b0100,
    EmDigits = 4'b1000
  } em_state_e;

  em_state_e                      state_q, state_d;
  logic [bda_pkg::BcdWidth-1:0]   dig_q, dig_d;
  logic [bda_pkg::LeftWidth-1:0]  left_q, left_d;
  logic                           neg_q, neg_d;
  logic                           out_valid_q, out_valid_d;
  logic [7:0]                     char_q, char_d;
  logic                           last_q, last_d;

  logic [3:0]                     top_digit;
  logic                           out_free;

  assign top_digit = dig_q[bda_pkg::BcdWidth-1 -: 4];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign take_o    = conv_i.valid && (state_q == EmIdle);

  always_comb begin
    state_d     = state_q;
    dig_d       = dig_q;
    left_d      = left_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    case (state_q)
      EmIdle: begin
        if (take_o) begin
          dig_d   = conv_i.bcd;
          neg_d   = conv_i.negative;
          left_d  = bda_pkg::LeftWidth'(bda_pkg::NumDigits);
          state_d = EmSkip;
        end
      end
      EmSkip: begin
        // The last digit always stays, so zero prints as a single '0'.
        if ((top_digit == 4'd0) && (left_q != bda_pkg::LeftWidth'(1))) begin
          dig_d  = {dig_q[bda_pkg::BcdWidth-5:0], 4'd0};
          left_d = left_q - 1'b1;
        end else begin
          state_d = neg_q ? EmSign : EmDigits;
        end
      end
      EmSign: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = bda_pkg::CharMinus;
          last_d      = 1'b0;
          state_d     = EmDigits;
        end
      end
      EmDigits: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = bda_pkg::CharZero + {4'd0, top_digit};
          last_d      = (left_q == bda_pkg::LeftWidth'(1));
          dig_d       = {dig_q[bda_pkg::BcdWidth-5:0], 4'd0};
          left_d      = left_q - 1'b1;
          if (left_q == bda_pkg::LeftWidth'(1)) begin
            state_d = EmIdle;
          end
        end
      end
      default: state_d = EmIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EmIdle;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign is_last_o   = last_q;

  `BDA_ASSERT(a_idle_after_last, (out_valid_q && !last_q) |-> (state_q != EmIdle), "number cut short")
  `BDA_ASSERT(a_char_legal, out_valid_q |-> (((char_q >= bda_pkg::CharZero) && (char_q <= bda_pkg::CharNine)) || (char_q == bda_pkg::CharMinus)), "bad character")

endmodule

/* src/binary_to_decimal_ascii.sv */
// Decimal ASCII text of a 32-bit word, signed or unsigned, one character per
// output item, most significant first, with is_last on the final character.
// Depends on bda_pkg, bda_conv and bda_emit.
//
// The bit-serial shift-add-3 converter handles one bit of the magnitude per
// cycle and holds its BCD result until the emitter takes it; it stalls the
// input until then. The emitter takes the result, drops each leading zero,
// finds the first significant digit and sends the sign of a negative word,
// then the digits, one character per output item; this overlaps with the
// conversion of the next item. Negative signed words print as '-' followed
// by the true magnitude, the most negative value included; zero prints as a
// single '0'.
module binary_to_decimal_ascii (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bda_pkg::InWidth-1:0]  value_bits_i,
  input  logic                         is_signed_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   text_char_o,
  output logic                         is_last_o
);

  bda_pkg::bda_conv_t conv;
  logic               take;

  bda_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_bits_i (value_bits_i),
    .is_signed_i  (is_signed_i),
    .conv_o       (conv),
    .take_i       (take)
  );

  bda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .conv_i      (conv),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .is_last_o   (is_last_o)
  );

endmodule
